// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Implication checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/aps_pkg.sv =====
// Types, constants and helpers for the packed pixel sampler.
package aps_pkg;

    localparam int SRC_BYTES_DEF = 4096;   // must be a power of two, 256 to 65536
    localparam int FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH   = 4;
    localparam int ADDR_MAX_W    = 16;

    // item commands
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_SET    = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;

    // register indexes
    localparam logic [2:0] REG_BPP_CODE    = 3'd0;
    localparam logic [2:0] REG_IMAGE_W     = 3'd1;
    localparam logic [2:0] REG_IMAGE_H     = 3'd2;
    localparam logic [2:0] REG_ROW_PITCH   = 3'd3;
    localparam logic [2:0] REG_STEP_X      = 3'd4;
    localparam logic [2:0] REG_STEP_Y      = 3'd5;
    localparam logic [2:0] REG_TRANSP_IDX  = 3'd6;
    localparam logic [2:0] REG_FORE_COLOR  = 3'd7;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [11:0]        byte_addr;
        logic [7:0]         byte_data;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  raw_index;
        logic        is_transparent;
        logic        is_outside;
        logic [31:0] argb;
    } out_item_t;

    typedef struct packed {
        logic [1:0]         bpp_code;
        logic [15:0]        image_width;
        logic [15:0]        image_height;
        logic [15:0]        row_pitch;
        logic signed [31:0] step_x;
        logic signed [31:0] step_y;
        logic [7:0]         transparent_index;
        logic [23:0]        fore_color;
    } cfg_t;

    // one queued job: a byte load or a pixel read
    typedef struct packed {
        logic                  is_load;
        logic                  in_bounds;
        logic [ADDR_MAX_W-1:0] addr;
        logic [2:0]            offset;
        logic [7:0]            data;
    } job_t;

    // alpha gain that spreads an n-bit value over 8 bits
    function automatic logic [7:0] alpha_gain(input logic [1:0] bpp);
        logic [7:0] g;
        unique case (bpp)
            2'd0: g = 8'hFF;
            2'd1: g = 8'h55;
            2'd2: g = 8'h11;
            2'd3: g = 8'h01;
        endcase
        return g;
    endfunction

endpackage

// ===== sv/aps_front.sv =====
// Front end: takes items, steps the walker, checks bounds, forms byte addresses.
module aps_front #(
    parameter int FRAC_BITS = aps_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  aps_pkg::in_item_t in_data,
    input  aps_pkg::cfg_t     cfg,
    output logic              job_valid,
    input  logic              job_ready,
    output aps_pkg::job_t     job
);

    logic [31:0] walker_x_reg, walker_y_reg;
    logic        a_valid_reg, b_valid_reg;
    logic        a_load_reg, a_inside_reg;
    logic [15:0] a_x_reg, a_y_reg;
    logic [11:0] a_addr_reg;
    logic [7:0]  a_data_reg;
    aps_pkg::job_t b_job_reg, b_job_next;

    logic        accept, a_take, b_take;
    logic [31:0] x_int, y_int;
    logic        in_bounds;
    logic [31:0] prod;
    logic [32:0] pix_idx;
    logic [35:0] bit_addr;

    assign b_take   = !b_valid_reg || job_ready;
    assign a_take   = !a_valid_reg || b_take;
    assign in_ready = a_take;
    assign accept   = in_valid && in_ready;

    // negative walker values always land outside
    assign x_int     = walker_x_reg >> FRAC_BITS;
    assign y_int     = walker_y_reg >> FRAC_BITS;
    assign in_bounds = !walker_x_reg[31] && !walker_y_reg[31]
                       && (x_int < {16'd0, cfg.image_width})
                       && (y_int < {16'd0, cfg.image_height});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walker_x_reg <= '0;
            walker_y_reg <= '0;
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept && in_data.cmd == aps_pkg::CMD_SET)
            begin
                walker_x_reg <= in_data.start_x;
                walker_y_reg <= in_data.start_y;
            end
            else if (accept && in_data.cmd == aps_pkg::CMD_SAMPLE)
            begin
                walker_x_reg <= walker_x_reg + 32'(cfg.step_x);
                walker_y_reg <= walker_y_reg + 32'(cfg.step_y);
            end
            if (a_take)
                a_valid_reg <= accept && (in_data.cmd == aps_pkg::CMD_LOAD
                                          || in_data.cmd == aps_pkg::CMD_SAMPLE);
            if (b_take)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_take)
        begin
            a_load_reg   <= in_data.cmd == aps_pkg::CMD_LOAD;
            a_inside_reg <= in_bounds;
            a_x_reg      <= x_int[15:0];
            a_y_reg      <= y_int[15:0];
            a_addr_reg   <= in_data.byte_addr;
            a_data_reg   <= in_data.byte_data;
        end
        if (b_take)
            b_job_reg <= b_job_next;
    end

    // pixel bit address = (x + y * pitch) << bpp
    assign prod     = a_y_reg * cfg.row_pitch;
    assign pix_idx  = {17'd0, a_x_reg} + {1'b0, prod};
    assign bit_addr = {3'd0, pix_idx} << cfg.bpp_code;

    always_comb
    begin
        b_job_next.is_load   = a_load_reg;
        b_job_next.in_bounds = a_inside_reg;
        b_job_next.data      = a_data_reg;
        if (a_load_reg)
        begin
            b_job_next.addr   = aps_pkg::ADDR_MAX_W'(a_addr_reg);
            b_job_next.offset = 3'd0;
        end
        else
        begin
            b_job_next.addr   = bit_addr[aps_pkg::ADDR_MAX_W+2:3];
            b_job_next.offset = bit_addr[2:0];
        end
    end

    assign job_valid = b_valid_reg;
    assign job       = b_job_reg;

endmodule

// ===== sv/aps_queue.sv =====
// Short job queue between the front and back ends.
module aps_queue #(
    parameter int DEPTH = aps_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  aps_pkg::job_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output aps_pkg::job_t pop_data
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    aps_pkg::job_t  slots_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            push, pop;

    assign push_ready = count_reg != CntW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== sv/aps_back.sv =====
// Back end: source memory, pixel extraction and the output register.
module aps_back #(
    parameter int SRC_BYTES = aps_pkg::SRC_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_ready,
    input  aps_pkg::job_t      job,
    input  aps_pkg::cfg_t      cfg,
    output logic               out_valid,
    input  logic               out_ready,
    output aps_pkg::out_item_t out_data
);

    localparam int AddrW = $clog2(SRC_BYTES);

    logic [7:0] mem [SRC_BYTES];

    logic       r_valid_reg, r_inside_reg;
    logic [2:0] r_offset_reg;
    logic [7:0] rd_data_reg;
    logic       o_valid_reg;
    aps_pkg::out_item_t o_data_reg, o_data_next;

    logic             pop, o_take, r_move;
    logic [AddrW-1:0] addr;
    logic [3:0]       bits;
    logic [2:0]       shift;
    logic [7:0]       mask, raw;
    logic [15:0]      alpha_prod;

    assign o_take    = !o_valid_reg || out_ready;
    assign r_move    = r_valid_reg && o_take;
    assign job_ready = !r_valid_reg || o_take;
    assign pop       = job_valid && job_ready;
    assign addr      = job.addr[AddrW-1:0];

    // one port: a transfer is either a byte write or a byte read
    always_ff @(posedge clk)
    begin
        if (pop && job.is_load)
            mem[addr] <= job.data;
        if (pop && !job.is_load)
        begin
            rd_data_reg  <= mem[addr];
            r_inside_reg <= job.in_bounds;
            r_offset_reg <= job.offset;
        end
        if (r_move)
            o_data_reg <= o_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_ready)
                r_valid_reg <= pop && !job.is_load;
            if (o_take)
                o_valid_reg <= r_valid_reg;
        end
    end

    // MSB-first packing: shift = (8 - (offset + bits)) mod 8
    assign bits       = 4'(4'd1 << cfg.bpp_code);
    assign shift      = 3'(4'd8 - ({1'b0, r_offset_reg} + bits));
    assign mask       = 8'((9'd1 << bits) - 9'd1);
    assign raw        = r_inside_reg ? ((rd_data_reg >> shift) & mask) : 8'd0;
    assign alpha_prod = aps_pkg::alpha_gain(cfg.bpp_code) * raw;

    always_comb
    begin
        o_data_next.raw_index      = raw;
        o_data_next.is_transparent = raw == cfg.transparent_index;
        o_data_next.is_outside     = !r_inside_reg;
        o_data_next.argb           = {alpha_prod[7:0], cfg.fore_color};
    end

    assign out_valid = o_valid_reg;
    assign out_data  = o_data_reg;

endmodule

// ===== sv/affine_packed_pixel_sampler.sv =====
// Top level of the affine sampler over a packed source bitmap.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | in_data  (load, set position, sample)
//  out     | output    | out_valid / out_ready | out_data (one per sample)
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One item per cycle while the output is not stalled; a sample result passes through
//  two front stages, a queue slot, the memory read and the output register.
//  Source memory is single ported: each cycle the back end does one load or one read.
//  Reset clears the walker and all valid flags, presets the registers; memory is not cleared.
//  Front and back stall on their own; the 4-entry queue absorbs output stalls.
module affine_packed_pixel_sampler #(
    parameter int SRC_BYTES = aps_pkg::SRC_BYTES_DEF,
    parameter int FRAC_BITS = aps_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  aps_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output aps_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    aps_pkg::cfg_t cfg_reg;
    aps_pkg::job_t front_job, back_job;
    logic          front_valid, front_ready, back_valid, back_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bpp_code          <= 2'd3;
            cfg_reg.image_width       <= '0;
            cfg_reg.image_height      <= '0;
            cfg_reg.row_pitch         <= '0;
            cfg_reg.step_x            <= 32'sd65536;
            cfg_reg.step_y            <= '0;
            cfg_reg.transparent_index <= '0;
            cfg_reg.fore_color        <= 24'hFFFFFF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                aps_pkg::REG_BPP_CODE:   cfg_reg.bpp_code          <= cfg_data[1:0];
                aps_pkg::REG_IMAGE_W:    cfg_reg.image_width       <= cfg_data[15:0];
                aps_pkg::REG_IMAGE_H:    cfg_reg.image_height      <= cfg_data[15:0];
                aps_pkg::REG_ROW_PITCH:  cfg_reg.row_pitch         <= cfg_data[15:0];
                aps_pkg::REG_STEP_X:     cfg_reg.step_x            <= cfg_data;
                aps_pkg::REG_STEP_Y:     cfg_reg.step_y            <= cfg_data;
                aps_pkg::REG_TRANSP_IDX: cfg_reg.transparent_index <= cfg_data[7:0];
                aps_pkg::REG_FORE_COLOR: cfg_reg.fore_color        <= cfg_data[23:0];
            endcase
        end
    end

    aps_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg       (cfg_reg),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    aps_queue #(
        .DEPTH (aps_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_job)
    );

    aps_back #(
        .SRC_BYTES (SRC_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .job       (back_job),
        .cfg       (cfg_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== sv/aps_checker.sv =====
// Port-level checks for the sampler, bound to the top level.
`include "assert_macros.svh"

module aps_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input aps_pkg::out_item_t out_data
);

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

    // outside samples carry a zero index and zero alpha
    `ASSERT_IMPLY(a_outside_zero, clk, rst_n, out_valid && out_data.is_outside, out_data.raw_index == 8'd0 && out_data.argb[31:24] == 8'd0)

    // no result at the first edge after reset
    `ASSERT_ALWAYS(a_reset_quiet, clk, rst_n && !$past(rst_n), !out_valid)

endmodule

bind affine_packed_pixel_sampler aps_checker u_aps_checker (.*);

// ===== verif/tb_affine_packed_pixel_sampler.sv =====
// Self-checking testbench for the affine packed pixel sampler.
`timescale 1ns / 1ps

module tb_affine_packed_pixel_sampler;

    localparam int SRC_BYTES = aps_pkg::SRC_BYTES_DEF;
    localparam int FRAC_BITS = aps_pkg::FRAC_BITS_DEF;
    localparam int ADDR_W = $clog2(SRC_BYTES);
    localparam int ITEM_TARGET = 1550;
    localparam int SETTLE_CYCLES = 8;

    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam logic [1:0] BPP_1 = 2'd0;
    localparam logic [1:0] BPP_2 = 2'd1;
    localparam logic [1:0] BPP_4 = 2'd2;
    localparam logic [1:0] BPP_8 = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    aps_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    aps_pkg::out_item_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // register shadow, updated on each cfg transfer
    aps_pkg::cfg_t cfg_now = '{bpp_code: BPP_8, image_width: 16'd0, image_height: 16'd0,
                               row_pitch: 16'd0, step_x: 32'sd65536, step_y: 32'sd0,
                               transparent_index: 8'd0, fore_color: 24'hFF_FFFF};

    // walker and memory as seen by accepted transfers
    logic [7:0] src_mem [SRC_BYTES];
    logic [31:0] walk_x = '0;
    logic [31:0] walk_y = '0;
    aps_pkg::out_item_t expected_pixels[$];

    // stimulus side: walker as planned, bytes already loaded
    logic [31:0] plan_x = '0;
    logic [31:0] plan_y = '0;
    bit loaded_map [SRC_BYTES];
    aps_pkg::in_item_t pending_items[$];
    int n_items = 0;

    int mismatch_count = 0;
    logic in_fire = 1'b0;
    int burst_left = 1;
    int gap_left = 0;
    logic [7:0] rx_phase = '0;
    logic [15:0] rx_pat = 16'hFFFF;

    affine_packed_pixel_sampler dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // byte address and bit shift of the pixel under a walker position
    function automatic void pixel_location(input logic [31:0] wx, input logic [31:0] wy,
                                           output logic in_img,
                                           output logic [ADDR_W-1:0] addr,
                                           output logic [2:0] shift);
        logic [31:0] xi;
        logic [31:0] yi;
        logic [63:0] bit_pos;
        logic [3:0] nbits;
        // negative positions map to all ones, which is always outside
        xi = wx[31] ? '1 : wx >> FRAC_BITS;
        yi = wy[31] ? '1 : wy >> FRAC_BITS;
        nbits = 4'd1 << cfg_now.bpp_code;
        in_img = (xi < cfg_now.image_width) && (yi < cfg_now.image_height);
        bit_pos = (64'(xi) + 64'(yi) * 64'(cfg_now.row_pitch)) << cfg_now.bpp_code;
        addr = ADDR_W'((bit_pos >> 3) % SRC_BYTES);
        shift = 3'(4'd8 - (4'(bit_pos[2:0]) + nbits));
    endfunction

    task automatic track_item(input aps_pkg::in_item_t it);
        logic in_img;
        logic [ADDR_W-1:0] addr;
        logic [2:0] shift;
        logic [7:0] mask;
        logic [7:0] raw;
        logic [7:0] gain;
        aps_pkg::out_item_t px;
        case (it.cmd)
            aps_pkg::CMD_LOAD: src_mem[it.byte_addr % SRC_BYTES] = it.byte_data;
            aps_pkg::CMD_SET:
            begin
                walk_x = it.start_x;
                walk_y = it.start_y;
            end
            aps_pkg::CMD_SAMPLE:
            begin
                pixel_location(walk_x, walk_y, in_img, addr, shift);
                mask = 8'((9'd1 << (4'd1 << cfg_now.bpp_code)) - 9'd1);
                raw = in_img ? ((src_mem[addr] >> shift) & mask) : 8'd0;
                case (cfg_now.bpp_code)
                    BPP_1: gain = 8'hFF;
                    BPP_2: gain = 8'h55;
                    BPP_4: gain = 8'h11;
                    default: gain = 8'h01;
                endcase
                px.raw_index = raw;
                px.is_transparent = (raw == cfg_now.transparent_index);
                px.is_outside = !in_img;
                px.argb = {8'(gain * raw), cfg_now.fore_color};
                expected_pixels.push_back(px);
                walk_x = walk_x + cfg_now.step_x;
                walk_y = walk_y + cfg_now.step_y;
            end
            default: ;
        endcase
    endtask

    // monitor: input and cfg transfers feed the shadow, results are checked
    always @(posedge clk)
    begin
        aps_pkg::out_item_t exp_px;
        in_fire = rst_n && in_valid && in_ready;
        if (in_fire)
            track_item(in_data);
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                aps_pkg::REG_BPP_CODE: cfg_now.bpp_code = cfg_data[1:0];
                aps_pkg::REG_IMAGE_W: cfg_now.image_width = cfg_data[15:0];
                aps_pkg::REG_IMAGE_H: cfg_now.image_height = cfg_data[15:0];
                aps_pkg::REG_ROW_PITCH: cfg_now.row_pitch = cfg_data[15:0];
                aps_pkg::REG_STEP_X: cfg_now.step_x = cfg_data;
                aps_pkg::REG_STEP_Y: cfg_now.step_y = cfg_data;
                aps_pkg::REG_TRANSP_IDX: cfg_now.transparent_index = cfg_data[7:0];
                aps_pkg::REG_FORE_COLOR: cfg_now.fore_color = cfg_data[23:0];
                default: ;
            endcase
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected result transfer: %h", out_data);
                mismatch_count++;
            end
            else
            begin
                exp_px = expected_pixels.pop_front();
                if (out_data.raw_index !== exp_px.raw_index)
                begin
                    $error("raw_index: expected %0h, got %0h",
                           exp_px.raw_index, out_data.raw_index);
                    mismatch_count++;
                end
                if (out_data.is_transparent !== exp_px.is_transparent)
                begin
                    $error("is_transparent: expected %0b, got %0b",
                           exp_px.is_transparent, out_data.is_transparent);
                    mismatch_count++;
                end
                if (out_data.is_outside !== exp_px.is_outside)
                begin
                    $error("is_outside: expected %0b, got %0b",
                           exp_px.is_outside, out_data.is_outside);
                    mismatch_count++;
                end
                if (out_data.argb !== exp_px.argb)
                begin
                    $error("argb: expected %08h, got %08h", exp_px.argb, out_data.argb);
                    mismatch_count++;
                end
            end
        end
    end

    // driver: bursts of transfers separated by random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                in_data <= pending_items.pop_front();
                in_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stalls follow a 16-bit pattern, reshuffled each time the 8-bit phase counter wraps
    always @(negedge clk)
    begin
        rx_phase <= rx_phase + 8'd1;
        if (rx_phase == 8'hFF)
            rx_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        out_ready <= rx_pat[rx_phase[3:0]];
    end

    function automatic aps_pkg::in_item_t rand_item(input logic [1:0] cmd);
        aps_pkg::in_item_t it;
        it.cmd = cmd;
        it.byte_addr = 12'($urandom);
        it.byte_data = 8'($urandom);
        it.start_x = $urandom;
        it.start_y = $urandom;
        return it;
    endfunction

    function automatic aps_pkg::in_item_t load_item(input logic [11:0] addr,
                                                    input logic [7:0] data);
        aps_pkg::in_item_t it;
        it = rand_item(aps_pkg::CMD_LOAD);
        it.byte_addr = addr;
        it.byte_data = data;
        return it;
    endfunction

    function automatic aps_pkg::in_item_t set_item(input logic [31:0] x, input logic [31:0] y);
        aps_pkg::in_item_t it;
        it = rand_item(aps_pkg::CMD_SET);
        it.start_x = x;
        it.start_y = y;
        return it;
    endfunction

    // queue an item; a sample that would hit a never-loaded byte gets a load first
    task automatic queue_item(input aps_pkg::in_item_t it);
        logic in_img;
        logic [ADDR_W-1:0] addr;
        logic [2:0] shift;
        case (it.cmd)
            aps_pkg::CMD_LOAD: loaded_map[it.byte_addr % SRC_BYTES] = 1'b1;
            aps_pkg::CMD_SET:
            begin
                plan_x = it.start_x;
                plan_y = it.start_y;
            end
            aps_pkg::CMD_SAMPLE:
            begin
                pixel_location(plan_x, plan_y, in_img, addr, shift);
                if (in_img && !loaded_map[addr])
                begin
                    loaded_map[addr] = 1'b1;
                    pending_items.push_back(load_item(12'(addr), 8'($urandom)));
                    n_items++;
                end
                plan_x = plan_x + cfg_now.step_x;
                plan_y = plan_y + cfg_now.step_y;
            end
            default: ;
        endcase
        pending_items.push_back(it);
        if (it.cmd != CMD_NONE)
            n_items++;
    endtask

    task automatic wait_idle();
        while (!(pending_items.size() == 0 && !in_valid && expected_pixels.size() == 0))
            @(posedge clk);
        // loads and set-position items leave no result behind them
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic program_cfg(input aps_pkg::cfg_t c);
        logic [31:0] pad;
        // junk above the field width must be ignored
        pad = ($urandom_range(0, 1) != 0) ? $urandom : 32'd0;
        write_reg(aps_pkg::REG_BPP_CODE, {pad[31:2], c.bpp_code});
        write_reg(aps_pkg::REG_IMAGE_W, {pad[31:16], c.image_width});
        write_reg(aps_pkg::REG_IMAGE_H, {pad[31:16], c.image_height});
        write_reg(aps_pkg::REG_ROW_PITCH, {pad[31:16], c.row_pitch});
        write_reg(aps_pkg::REG_STEP_X, c.step_x);
        write_reg(aps_pkg::REG_STEP_Y, c.step_y);
        write_reg(aps_pkg::REG_TRANSP_IDX, {pad[31:8], c.transparent_index});
        write_reg(aps_pkg::REG_FORE_COLOR, {pad[31:24], c.fore_color});
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_dim(input int hi);
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 16'd0;
        if (r == 1)
            return 16'h8000;
        return 16'($urandom_range(1, hi));
    endfunction

    function automatic logic [31:0] pick_step();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 32'h8000_0000;
        if (r == 1)
            return 32'h7FFF_FFFF;
        return $urandom_range(0, 32'h4_0000) - 32'h2_0000;
    endfunction

    function automatic aps_pkg::cfg_t random_cfg(input int ph);
        aps_pkg::cfg_t c;
        c.bpp_code = 2'(ph);
        c.image_width = pick_dim(64);
        c.image_height = pick_dim(32);
        c.row_pitch = pick_dim(300);
        c.step_x = pick_step();
        c.step_y = pick_step();
        c.transparent_index = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
        c.fore_color = 24'($urandom);
        if (ph == 0)
        begin
            c.image_width = 16'h8000;
            c.image_height = 16'h8000;
            c.row_pitch = 16'h8000;
            c.step_x = 32'h7FFF_FFFF;
            c.step_y = 32'h8000_0000;
            c.transparent_index = 8'hFF;
            c.fore_color = 24'hFF_FFFF;
        end
        else if (ph == 1)
        begin
            c.image_width = 16'd0;
            c.image_height = 16'd0;
            c.row_pitch = 16'd0;
            c.step_x = 32'h8000_0000;
            c.step_y = 32'h7FFF_FFFF;
            c.transparent_index = 8'd0;
            c.fore_color = 24'd0;
        end
        return c;
    endfunction

    // mostly walks from a point inside the image, the rest noise
    task automatic queue_sequence();
        int r;
        int xi;
        int yi;
        r = $urandom_range(0, 9);
        if (r < 7)
        begin
            xi = (cfg_now.image_width != 0) ? $urandom_range(0, cfg_now.image_width - 1)
                                            : $urandom_range(0, 7);
            yi = (cfg_now.image_height != 0) ? $urandom_range(0, cfg_now.image_height - 1)
                                             : $urandom_range(0, 7);
            queue_item(set_item({1'b0, 15'(xi), 16'($urandom)},
                                {1'b0, 15'(yi), 16'($urandom)}));
            repeat ($urandom_range(1, 12))
            begin
                if ($urandom_range(0, 7) == 0)
                    queue_item(rand_item(aps_pkg::CMD_LOAD));
                queue_item(rand_item(aps_pkg::CMD_SAMPLE));
            end
        end
        else if (r == 7)
            queue_item(rand_item(aps_pkg::CMD_LOAD));
        else if (r == 8)
        begin
            queue_item(rand_item(aps_pkg::CMD_SET));
            repeat ($urandom_range(1, 4))
                queue_item(rand_item(aps_pkg::CMD_SAMPLE));
        end
        else
        begin
            queue_item(rand_item(CMD_NONE));
            queue_item(rand_item(aps_pkg::CMD_SAMPLE));
        end
    endtask

    initial
    begin
        int ph;
        int phase_start;
        int phase_len;
        bit paused;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: empty image, every sample is outside
        queue_item(rand_item(aps_pkg::CMD_SAMPLE));
        queue_item(rand_item(CMD_NONE));
        queue_item(set_item(32'h8000_0000, 32'h7FFF_FFFF));
        queue_item(rand_item(aps_pkg::CMD_SAMPLE));
        queue_item(set_item(32'h0000_FFFF, 32'h0));
        queue_item(rand_item(aps_pkg::CMD_SAMPLE));
        wait_idle();

        // wide image, rows past the end of memory wrap around
        program_cfg('{bpp_code: BPP_8, image_width: 16'h8000, image_height: 16'd2,
                      row_pitch: 16'd4096, step_x: 32'sh1_0000, step_y: 32'sh1_0000,
                      transparent_index: 8'hFF, fore_color: 24'd0});
        queue_item(load_item(12'd0, 8'hFF));
        queue_item(load_item(12'hFFF, 8'h00));
        queue_item(set_item(32'h0, 32'h0));
        queue_item(rand_item(aps_pkg::CMD_SAMPLE));
        queue_item(rand_item(aps_pkg::CMD_SAMPLE));
        queue_item(set_item(32'h7FFF_FFFF, 32'h0));
        queue_item(rand_item(aps_pkg::CMD_SAMPLE));
        // x has wrapped negative here
        queue_item(rand_item(aps_pkg::CMD_SAMPLE));

        ph = 0;
        while (n_items < ITEM_TARGET)
        begin
            wait_idle();
            program_cfg(random_cfg(ph));
            phase_len = $urandom_range(60, 140);
            phase_start = n_items;
            paused = 1'b0;
            while (n_items - phase_start < phase_len)
            begin
                // in phases with ph % 3 == 1, hold off mid-phase until every result is back
                if (ph % 3 == 1 && !paused && n_items - phase_start >= phase_len / 2)
                begin
                    wait_idle();
                    paused = 1'b1;
                end
                queue_sequence();
            end
            ph++;
        end

        wait_idle();
        if (mismatch_count == 0 && expected_pixels.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/aps_pkg.sv
sv/aps_front.sv
sv/aps_queue.sv
sv/aps_back.sv
sv/affine_packed_pixel_sampler.sv
sv/aps_checker.sv
verif/tb_affine_packed_pixel_sampler.sv
